/* rtl/cltnw_pkg.sv */
// Shared types, constants and helper functions for the character LCD nibble writer.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps
`default_nettype none

package cltnw_pkg;

    localparam int COL_W  = 6;
    localparam int ROW_W  = 2;
    localparam int ROWS_W = 3;
    localparam int CHAR_W = 8;
    localparam int NIB_W  = 4;
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;

    localparam logic [COL_W-1:0]  COLUMNS_RESET = 6'd16;
    localparam logic [ROWS_W-1:0] ROWS_RESET    = 3'd2;

    // Register index, taken from paddr[2].
    localparam logic REG_COLUMNS = 1'b0;
    localparam logic REG_ROWS    = 1'b1;

    localparam logic CMD_SET_POSITION = 1'b0;
    localparam logic CMD_WRITE_CHAR   = 1'b1;

    localparam logic RS_INSTRUCTION = 1'b0;
    localparam logic RS_DATA        = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_RETURN  = 8'd13;

    localparam logic [CHAR_W-1:0] SET_ADDR_CMD = 8'h80;

    localparam logic [CHAR_W-1:0] ROW_OFFSET [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

    // Up to two bytes produced by one request; the optional wrap instruction goes first.
    typedef struct packed {
        logic              has_wrap;
        logic [CHAR_W-1:0] wrap_byte;
        logic [CHAR_W-1:0] main_byte;
        logic              main_rs;
    } cltnw_bytes_t;

    // A row at or past the row count, or past the last physical row, folds to 0.
    function automatic logic [ROW_W-1:0] fit_row(input logic [ROWS_W-1:0] row,
                                                 input logic [ROWS_W-1:0] rows);
        logic [ROW_W-1:0] res;
        if (row >= rows || row > 3'd3)
            res = '0;
        else
            res = row[ROW_W-1:0];
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] set_address(input logic [COL_W-1:0] col,
                                                      input logic [ROW_W-1:0] row);
        logic [CHAR_W-1:0] sum;
        sum = {2'b00, col} + ROW_OFFSET[row];
        return SET_ADDR_CMD | sum;
    endfunction

endpackage

`default_nettype wire

/* rtl/cltnw_text_if.sv */
// Request channel carrying one text item (position or character).
// Depends on cltnw_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cltnw_text_if
    import cltnw_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              command;
    logic [COL_W-1:0]  start_column;
    logic [ROW_W-1:0]  start_row;
    logic [CHAR_W-1:0] character;

    modport source (output valid, command, start_column, start_row, character,
                    input ready);
    modport sink   (input valid, command, start_column, start_row, character,
                    output ready);
endinterface

`default_nettype wire

/* rtl/cltnw_nibble_if.sv */
// Result channel carrying one LCD bus nibble with its register select and last flag.
// Depends on cltnw_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface cltnw_nibble_if
    import cltnw_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [NIB_W-1:0] nibble;
    logic             register_select;
    logic             last;

    modport source (output valid, nibble, register_select, last, input ready);
    modport sink   (input valid, nibble, register_select, last, output ready);
endinterface

`default_nettype wire

/* rtl/cltnw_nibble_tx.sv */
// Output buffer and serializer: holds the bytes of one request and sends them as nibbles.
// Depends on cltnw_pkg and cltnw_nibble_if.
`timescale 1ns / 1ps
`default_nettype none

module cltnw_nibble_tx
    import cltnw_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire cltnw_bytes_t bytes,
    output logic              free,
    cltnw_nibble_if.source    nib_out
);

    logic              valid_reg;
    logic [1:0]        idx_reg;
    logic [CHAR_W-1:0] wrap_byte_reg;
    logic [CHAR_W-1:0] main_byte_reg;
    logic              main_rs_reg;
    logic [CHAR_W-1:0] cur_byte;
    logic              out_fire;
    logic              on_last;

    // Index 0/1 walk the wrap instruction, 2/3 the main byte; a single-byte
    // request starts at 2.
    assign cur_byte = idx_reg[1] ? main_byte_reg : wrap_byte_reg;
    assign on_last  = (idx_reg == 2'd3);
    assign out_fire = valid_reg && nib_out.ready;
    assign free     = !valid_reg || (on_last && nib_out.ready);

    assign nib_out.valid           = valid_reg;
    assign nib_out.nibble          = idx_reg[0] ? cur_byte[3:0] : cur_byte[7:4];
    assign nib_out.register_select = idx_reg[1] ? main_rs_reg : RS_INSTRUCTION;
    assign nib_out.last            = on_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= bytes.has_wrap ? 2'd0 : 2'd2;
        end
        else if (out_fire)
        begin
            if (on_last)
                valid_reg <= 1'b0;
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            wrap_byte_reg <= bytes.wrap_byte;
            main_byte_reg <= bytes.main_byte;
            main_rs_reg   <= bytes.main_rs;
        end
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (!valid_reg || (on_last && nib_out.ready)))
        else $error("request loaded over an unfinished one");

    a_idx_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !on_last) |=> (valid_reg && idx_reg == $past(idx_reg) + 2'd1))
        else $error("nibble index did not advance");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && on_last && !load) |=> !valid_reg)
        else $error("buffer still valid after its last nibble");

endmodule

`default_nettype wire

/* rtl/char_lcd_text_nibble_writer.sv */
// The first nibble of a request is shown in the cycle after the request is taken, from a registered buffer.
// Each request sends two or four nibbles as the receiver takes them; the single output
// buffer in cltnw_nibble_tx takes the next request on the cycle its last nibble leaves.
// Reset: cursor at column 0, row 0; columns 16, rows 2; output buffer empty.
// Holds the configuration registers, the cursor and the per-request byte selection.
// Depends on cltnw_pkg, cltnw_text_if, cltnw_nibble_if and cltnw_nibble_tx.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_text_nibble_writer
    import cltnw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready,
    cltnw_text_if.sink             text_in,
    cltnw_nibble_if.source         nib_out
);

    logic [COL_W-1:0]  columns_reg;
    logic [ROWS_W-1:0] rows_reg;
    logic [COL_W-1:0]  cur_col_reg;
    logic [ROW_W-1:0]  cur_row_reg;
    logic [COL_W-1:0]  cur_col_next;
    logic [ROW_W-1:0]  cur_row_next;

    logic              cfg_write;
    logic              accept;
    logic              tx_free;
    logic              wrap;
    logic [ROW_W-1:0]  wrap_row;
    logic [COL_W-1:0]  base_col;
    logic [ROW_W-1:0]  base_row;
    logic [ROW_W-1:0]  nl_row;
    logic [ROW_W-1:0]  pos_row;
    cltnw_bytes_t      bytes;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_COLUMNS: prdata[COL_W-1:0]  = columns_reg;
            REG_ROWS:    prdata[ROWS_W-1:0] = rows_reg;
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= COLUMNS_RESET;
            rows_reg    <= ROWS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_COLUMNS: columns_reg <= pwdata[COL_W-1:0];
                REG_ROWS:    rows_reg    <= pwdata[ROWS_W-1:0];
                default:     ;
            endcase
        end
    end

    assign text_in.ready = tx_free;
    assign accept        = text_in.valid && tx_free;

    // A character at a full line first moves the cursor to the next row's start.
    assign wrap     = (cur_col_reg >= columns_reg);
    assign wrap_row = fit_row({1'b0, cur_row_reg} + 3'd1, rows_reg);
    assign base_col = wrap ? '0 : cur_col_reg;
    assign base_row = wrap ? wrap_row : cur_row_reg;
    assign nl_row   = fit_row({1'b0, base_row} + 3'd1, rows_reg);
    assign pos_row  = fit_row({1'b0, text_in.start_row}, rows_reg);

    always_comb
    begin
        bytes.has_wrap  = 1'b0;
        bytes.wrap_byte = set_address('0, wrap_row);
        bytes.main_byte = text_in.character;
        bytes.main_rs   = RS_DATA;
        cur_col_next    = cur_col_reg;
        cur_row_next    = cur_row_reg;
        unique case (text_in.command)
            CMD_SET_POSITION:
            begin
                bytes.main_byte = set_address(text_in.start_column, pos_row);
                bytes.main_rs   = RS_INSTRUCTION;
                cur_col_next    = text_in.start_column;
                cur_row_next    = pos_row;
            end
            CMD_WRITE_CHAR:
            begin
                bytes.has_wrap = wrap;
                priority if (text_in.character == CHAR_NEWLINE)
                begin
                    bytes.main_byte = set_address(base_col, nl_row);
                    bytes.main_rs   = RS_INSTRUCTION;
                    cur_col_next    = base_col;
                    cur_row_next    = nl_row;
                end
                else if (text_in.character == CHAR_RETURN)
                begin
                    bytes.main_byte = set_address('0, base_row);
                    bytes.main_rs   = RS_INSTRUCTION;
                    cur_col_next    = '0;
                    cur_row_next    = base_row;
                end
                else
                begin
                    cur_col_next = base_col + 6'd1;
                    cur_row_next = base_row;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg <= '0;
            cur_row_reg <= '0;
        end
        else if (accept)
        begin
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
        end
    end

    cltnw_nibble_tx u_nibble_tx (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (accept),
        .bytes   (bytes),
        .free    (tx_free),
        .nib_out (nib_out)
    );

endmodule

`default_nettype wire

/* test/testbench.sv */
// Testbench for char_lcd_text_nibble_writer: position and character requests go in,
// and every LCD bus nibble that comes out is checked against a local cursor predictor.
// Depends on cltnw_pkg, cltnw_text_if, cltnw_nibble_if and the writer itself.
`timescale 1ns / 1ps

module testbench
    import cltnw_pkg::*;
;

    localparam int unsigned WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [NIB_W-1:0] nibble;
        logic             register_select;
        logic             last;
    } nibble_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    cltnw_text_if   text_ch ();
    cltnw_nibble_if nib_ch ();

    char_lcd_text_nibble_writer i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .text_in (text_ch),
        .nib_out (nib_ch)
    );

    // Predictor state: cursor plus a copy of the display geometry.
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cfg_columns;
    logic [ROWS_W-1:0] cfg_rows;

    nibble_t     pending_nibbles [$];
    int unsigned error_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned stall_left  = 0;
    bit          steady_flow = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (steady_flow || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void queue_byte(input logic [CHAR_W-1:0] value, input logic rs);
        nibble_t n;
        n.nibble          = value[7:4];
        n.register_select = rs;
        n.last            = 1'b0;
        pending_nibbles.push_back(n);
        n.nibble = value[3:0];
        pending_nibbles.push_back(n);
    endfunction

    // The row arrives one bit wider so that a step past row 3 can be seen and folded.
    function automatic void predict_move(input logic [COL_W-1:0] col,
                                         input logic [ROWS_W-1:0] row);
        logic [ROW_W-1:0]  fitted;
        logic [CHAR_W-1:0] addr;
        fitted     = (row >= cfg_rows || row > 3'd3) ? '0 : row[ROW_W-1:0];
        cursor_col = col;
        cursor_row = fitted;
        addr       = SET_ADDR_CMD | ({2'b00, col} + ROW_OFFSET[fitted]);
        queue_byte(addr, RS_INSTRUCTION);
    endfunction

    function automatic void predict_text(input logic cmd, input logic [COL_W-1:0] col,
                                         input logic [ROW_W-1:0] row,
                                         input logic [CHAR_W-1:0] ch);
        if (cmd == CMD_SET_POSITION)
            predict_move(col, {1'b0, row});
        else
        begin
            if (cursor_col >= cfg_columns)
                predict_move('0, {1'b0, cursor_row} + 3'd1);
            if (ch == CHAR_NEWLINE)
                predict_move(cursor_col, {1'b0, cursor_row} + 3'd1);
            else if (ch == CHAR_RETURN)
                predict_move('0, {1'b0, cursor_row});
            else
            begin
                queue_byte(ch, RS_DATA);
                cursor_col = cursor_col + 1'b1;
            end
        end
        pending_nibbles[pending_nibbles.size() - 1].last = 1'b1;
    endfunction

    // Called at a rising edge; valid stays high after acceptance so that
    // back-to-back requests need not drop valid in between.
    task automatic send_text(input logic cmd, input logic [COL_W-1:0] col,
                             input logic [ROW_W-1:0] row, input logic [CHAR_W-1:0] ch);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_ch.valid        <= 1'b1;
        text_ch.command      <= cmd;
        text_ch.start_column <= col;
        text_ch.start_row    <= row;
        text_ch.character    <= ch;
        do
            @(posedge clk);
        while (!text_ch.ready);
        predict_text(cmd, col, row, ch);
    endtask

    task automatic drain_nibbles();
        text_ch.valid <= 1'b0;
        while (pending_nibbles.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Returns psel low and idle before ending, so a following write starts cleanly.
    task automatic write_register(input logic [APB_AW-1:0] addr,
                                  input logic [APB_DW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_geometry(input logic [COL_W-1:0] columns,
                                input logic [ROWS_W-1:0] rows);
        drain_nibbles();
        write_register({REG_COLUMNS, 2'b00}, APB_DW'(columns));
        write_register({REG_ROWS, 2'b00}, APB_DW'(rows));
        cfg_columns = columns;
        cfg_rows    = rows;
    endtask

    // Reset geometry: 16 columns, 2 rows, so rows 2 and 3 fold back to row 0.
    task automatic test_set_position();
        send_text(CMD_SET_POSITION, 6'd0, 2'd0, 8'h00);
        send_text(CMD_SET_POSITION, 6'd39, 2'd3, 8'hFF);
        send_text(CMD_SET_POSITION, 6'd63, 2'd1, 8'hA5);
        send_text(CMD_SET_POSITION, 6'd5, 2'd2, CHAR_NEWLINE);
    endtask

    task automatic test_char_specials();
        send_text(CMD_SET_POSITION, 6'd14, 2'd1, 8'h00);
        send_text(CMD_WRITE_CHAR, 6'd63, 2'd3, 8'h00);
        send_text(CMD_WRITE_CHAR, 6'd0, 2'd0, 8'hFF);
        send_text(CMD_WRITE_CHAR, 6'd21, 2'd2, 8'h41);
        send_text(CMD_WRITE_CHAR, 6'd0, 2'd0, CHAR_NEWLINE);
        send_text(CMD_WRITE_CHAR, 6'd0, 2'd0, CHAR_RETURN);
    endtask

    // With seven rows configured, stepping past row 3 must still land on row 0.
    task automatic test_row_wrap();
        set_geometry(6'd2, 3'd7);
        send_text(CMD_SET_POSITION, 6'd1, 2'd3, 8'h00);
        send_text(CMD_WRITE_CHAR, 6'd0, 2'd0, 8'h78);
        send_text(CMD_WRITE_CHAR, 6'd0, 2'd0, CHAR_NEWLINE);
        send_text(CMD_SET_POSITION, 6'd0, 2'd3, 8'h00);
        send_text(CMD_WRITE_CHAR, 6'd0, 2'd0, CHAR_NEWLINE);
        send_text(CMD_WRITE_CHAR, 6'd0, 2'd0, CHAR_RETURN);
    endtask

    task automatic test_zero_geometry();
        set_geometry(6'd0, 3'd0);
        send_text(CMD_SET_POSITION, 6'd7, 2'd3, 8'h00);
        send_text(CMD_WRITE_CHAR, 6'd0, 2'd0, 8'h7A);
        send_text(CMD_WRITE_CHAR, 6'd0, 2'd0, CHAR_NEWLINE);
        send_text(CMD_WRITE_CHAR, 6'd0, 2'd0, CHAR_RETURN);
        set_geometry(6'd63, 3'd4);
        send_text(CMD_SET_POSITION, 6'd63, 2'd3, 8'h00);
        send_text(CMD_WRITE_CHAR, 6'd0, 2'd0, 8'h71);
    endtask

    task automatic send_random_items(input int unsigned count);
        int unsigned      roll;
        logic             cmd;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [CHAR_W-1:0] ch;
        repeat (count)
        begin
            roll = $urandom_range(99);
            cmd  = (roll < 20) ? CMD_SET_POSITION : CMD_WRITE_CHAR;
            col  = ($urandom_range(3) == 0) ? COL_W'($urandom_range(63))
                                            : COL_W'($urandom_range(39));
            row  = ROW_W'($urandom);
            roll = $urandom_range(99);
            if (roll < 12)
                ch = CHAR_NEWLINE;
            else if (roll < 20)
                ch = CHAR_RETURN;
            else
                ch = CHAR_W'($urandom);
            send_text(cmd, col, row, ch);
        end
    endtask

    task automatic test_random_traffic();
        set_geometry(6'd16, 3'd2);
        send_random_items(23);
        steady_flow = 1'b1;
        set_geometry(6'd40, 3'd4);
        send_random_items(23);
        steady_flow = 1'b0;
        set_geometry(6'd1, 3'd1);
        send_random_items(23);
        set_geometry(6'd63, 3'd7);
        send_random_items(23);
        set_geometry(6'd0, 3'd0);
        send_random_items(22);
        set_geometry(COL_W'($urandom_range(1, 40)), ROWS_W'($urandom_range(1, 4)));
        send_random_items(22);
    endtask

    initial
    begin
        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        text_ch.valid        <= 1'b0;
        text_ch.command      <= CMD_SET_POSITION;
        text_ch.start_column <= '0;
        text_ch.start_row    <= '0;
        text_ch.character    <= '0;
        cursor_col  = '0;
        cursor_row  = '0;
        cfg_columns = COLUMNS_RESET;
        cfg_rows    = ROWS_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_set_position();
        test_char_specials();
        test_row_wrap();
        test_zero_geometry();
        test_random_traffic();

        drain_nibbles();
        repeat (20) @(posedge clk);
        if (pending_nibbles.size() != 0)
        begin
            $error("nibbles still outstanding: %0d", pending_nibbles.size());
            error_count++;
        end
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Receiver: holds ready low for random stretches.
    initial
    begin
        nib_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                nib_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                nib_ch.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : check_nibbles
        nibble_t want;
        if (rst_n && nib_ch.valid && nib_ch.ready)
        begin
            if (pending_nibbles.size() == 0)
            begin
                $error("nibble %0h arrived with none outstanding", nib_ch.nibble);
                error_count++;
            end
            else
            begin
                want = pending_nibbles.pop_front();
                if (nib_ch.nibble !== want.nibble)
                begin
                    $error("nibble: expected %0h, got %0h", want.nibble, nib_ch.nibble);
                    error_count++;
                end
                if (nib_ch.register_select !== want.register_select)
                begin
                    $error("register_select: expected %0b, got %0b",
                           want.register_select, nib_ch.register_select);
                    error_count++;
                end
                if (nib_ch.last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, nib_ch.last);
                    error_count++;
                end
            end
        end
    end

    // Ends the run if neither channel moves and psel stays low for too long.
    always @(posedge clk)
    begin
        if ((text_ch.valid && text_ch.ready) || (nib_ch.valid && nib_ch.ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
